// ===== rtl/nks_pkg.sv =====
// Package for the next k-subset index unit.
// Holds field widths, configuration register codes and the lowest-set-bit search.
// No dependencies.
`timescale 1ns / 1ps

package nks_pkg;

   localparam int DEF_MASK_WIDTH  = 32;
   localparam int MAX_MASK_WIDTH  = 64;
   localparam int INDEX_WIDTH     = 5;
   localparam int BIT_POS_WIDTH   = $clog2(MAX_MASK_WIDTH);
   localparam int CSR_DATA_WIDTH  = 5;

   typedef logic [INDEX_WIDTH-1:0]    index_type;
   typedef logic [CSR_DATA_WIDTH-1:0] csr_data_type;
   typedef logic [BIT_POS_WIDTH-1:0]  bit_pos_type;

   typedef enum logic [0:0] {
      CSR_AMBIENT_DIMENSION = 1'b0,
      CSR_SUBSET_SIZE       = 1'b1
   } csr_index_type;

   localparam index_type RESET_AMBIENT_DIMENSION = 5'd8;
   localparam index_type RESET_SUBSET_SIZE       = 5'd4;

   // Position of the lowest set bit; zero when no bit is set.
   function automatic bit_pos_type lowest_set_bit(input logic [MAX_MASK_WIDTH-1:0] value);
      bit_pos_type pos;
      pos = '0;
      for (int i = MAX_MASK_WIDTH - 1; i >= 0; i--) begin
         if (value[i]) begin
            pos = BIT_POS_WIDTH'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ===== rtl/nks_ifs.sv =====
// Channel interfaces for the next k-subset index unit: request, response, CSR write.
// Depends on nks_pkg.
`timescale 1ns / 1ps

interface nks_req_if;
   import nks_pkg::*;
   logic      valid;
   logic      ready;
   index_type element_index;
   logic      is_last;
   modport source (output valid, element_index, is_last, input ready);
   modport sink   (input valid, element_index, is_last, output ready);
endinterface

interface nks_rsp_if;
   import nks_pkg::*;
   logic      valid;
   logic      ready;
   index_type subset_index;
   logic      is_last_res;
   modport source (output valid, subset_index, is_last_res, input ready);
   modport sink   (input valid, subset_index, is_last_res, output ready);
endinterface

interface nks_csr_if;
   import nks_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/nks_gosper.sv =====
// Successor mask of a k-subset by the same-popcount step, plus the end test.
// Depends on nks_pkg.
`timescale 1ns / 1ps

module nks_gosper #(
   parameter int MASK_WIDTH = nks_pkg::DEF_MASK_WIDTH
) (
   input  logic [MASK_WIDTH-1:0] member_mask,
   input  nks_pkg::index_type    ambient_dimension,
   input  nks_pkg::index_type    subset_size,
   output logic [MASK_WIDTH-1:0] emit_mask,
   output nks_pkg::index_type    emit_count
);
   import nks_pkg::*;

   logic [MASK_WIDTH-1:0]    filled;
   logic [MASK_WIDTH-1:0]    filled_inc;
   logic [MASK_WIDTH-1:0]    trailing_ones;
   logic [MASK_WIDTH-1:0]    fill;
   logic [MASK_WIDTH-1:0]    next_mask;
   logic [MASK_WIDTH-1:0]    next_shifted;
   logic [MASK_WIDTH-1:0]    below_n;
   logic [BIT_POS_WIDTH:0]   shift_amount;
   logic                     no_successor;

   assign filled        = member_mask | (member_mask - MASK_WIDTH'(1));
   assign filled_inc    = filled + MASK_WIDTH'(1);
   assign trailing_ones = filled & ~filled_inc;
   assign shift_amount  = {1'b0, lowest_set_bit(MAX_MASK_WIDTH'(member_mask))}
                          + (BIT_POS_WIDTH + 1)'(1);
   assign fill          = trailing_ones >> shift_amount;
   assign next_mask     = filled_inc | fill;
   assign next_shifted  = next_mask >> ambient_dimension;
   assign below_n       = ~({MASK_WIDTH{1'b1}} << ambient_dimension);
   assign no_successor  = (member_mask == '0) || next_shifted[0];

   always_comb begin
      if (no_successor || subset_size == '0) begin
         emit_mask = '0;
      end else begin
         emit_mask = next_mask & below_n;
      end
      if (no_successor || subset_size == '0) begin
         emit_count = index_type'(1);
      end else begin
         emit_count = subset_size;
      end
   end

endmodule

// ===== rtl/next_k_subset_indices_unit.sv =====
// Top level of the next k-subset index unit.
// Depends on nks_pkg, nks_ifs and nks_gosper.
//
// Member indices of a k-subset arrive one per beat and are OR-ed into a mask, one beat
// per cycle while the request side is not stalled. The beat marked last hands the mask
// to a capture register, from which the successor is formed in one pass and loaded into
// the emitter. The emitter sends one response beat per cycle while the response side is
// not stalled: the members of the next subset in ascending order, padded with 0 up to
// subset_size beats, or a single 0 beat when no subset follows or subset_size is 0. A
// subset of k members therefore occupies the output for max(k, 1) beats; the next subset
// may be accumulated meanwhile, and the request side stalls on any beat while the capture
// register still holds a subset that the emitter has not yet taken. CSR writes are taken in any cycle.
`timescale 1ns / 1ps

module next_k_subset_indices_unit #(
   parameter int MASK_WIDTH = nks_pkg::DEF_MASK_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   nks_req_if.sink    req_if,
   nks_rsp_if.source  rsp_if,
   nks_csr_if.sink    csr_if
);
   import nks_pkg::*;

   index_type             ambient_dimension_ff;
   index_type             subset_size_ff;

   logic [MASK_WIDTH-1:0] acc_mask_ff,  acc_mask_in;
   logic [MASK_WIDTH-1:0] cap_mask_ff,  cap_mask_in;
   logic                  cap_valid_ff, cap_valid_in;

   logic                  active_ff,    active_in;
   logic [MASK_WIDTH-1:0] rem_mask_ff,  rem_mask_in;
   index_type             sent_ff,      sent_in;
   index_type             count_ff,     count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   index_type             rsp_index_ff, rsp_index_in;
   logic                  rsp_last_ff,  rsp_last_in;

   logic [MASK_WIDTH-1:0] index_bit;
   logic [MASK_WIDTH-1:0] merged_mask;
   logic [MASK_WIDTH-1:0] emit_mask;
   index_type             emit_count;
   bit_pos_type           low_pos;
   logic                  req_beat;
   logic                  gen_beat;
   logic                  gen_last;
   logic                  emit_load;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ambient_dimension_ff <= RESET_AMBIENT_DIMENSION;
         subset_size_ff       <= RESET_SUBSET_SIZE;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_AMBIENT_DIMENSION: ambient_dimension_ff <= csr_if.data;
            CSR_SUBSET_SIZE:       subset_size_ff       <= csr_if.data;
            default:               ;
         endcase
      end
   end

   nks_gosper #(
      .MASK_WIDTH (MASK_WIDTH)
   ) u_gosper (
      .member_mask       (cap_mask_ff),
      .ambient_dimension (ambient_dimension_ff),
      .subset_size       (subset_size_ff),
      .emit_mask         (emit_mask),
      .emit_count        (emit_count)
   );

   assign gen_beat  = active_ff && (!rsp_valid_ff || rsp_if.ready);
   assign gen_last  = (sent_ff == count_ff - index_type'(1));
   assign emit_load = cap_valid_ff && (!active_ff || (gen_beat && gen_last));

   assign req_if.ready = !cap_valid_ff || emit_load;
   assign req_beat     = req_if.valid && req_if.ready;

   // An index of zero, or above MASK_WIDTH, sets no bit.
   always_comb begin
      index_bit = '0;
      for (int i = 0; i < MASK_WIDTH; i++) begin
         if (32'(req_if.element_index) == i + 1) begin
            index_bit[i] = 1'b1;
         end
      end
   end

   assign merged_mask = acc_mask_ff | index_bit;
   assign low_pos     = lowest_set_bit(MAX_MASK_WIDTH'(rem_mask_ff));

   always_comb begin
      acc_mask_in  = acc_mask_ff;
      cap_mask_in  = cap_mask_ff;
      cap_valid_in = cap_valid_ff && !emit_load;
      if (req_beat) begin
         if (req_if.is_last) begin
            acc_mask_in  = '0;
            cap_mask_in  = merged_mask;
            cap_valid_in = 1'b1;
         end else begin
            acc_mask_in  = merged_mask;
         end
      end

      active_in   = active_ff;
      rem_mask_in = rem_mask_ff;
      sent_in     = sent_ff;
      count_in    = count_ff;
      if (gen_beat) begin
         rem_mask_in = rem_mask_ff & (rem_mask_ff - MASK_WIDTH'(1));
         sent_in     = sent_ff + index_type'(1);
         if (gen_last) begin
            active_in = 1'b0;
         end
      end
      if (emit_load) begin
         active_in   = 1'b1;
         rem_mask_in = emit_mask;
         sent_in     = '0;
         count_in    = emit_count;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      if (gen_beat) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = gen_last;
         if (rem_mask_ff != '0) begin
            rsp_index_in = index_type'(low_pos) + index_type'(1);
         end else begin
            rsp_index_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_mask_ff  <= '0;
         cap_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_mask_ff  <= acc_mask_in;
         cap_valid_ff <= cap_valid_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_mask_ff  <= cap_mask_in;
      rem_mask_ff  <= rem_mask_in;
      sent_ff      <= sent_in;
      count_ff     <= count_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.subset_index = rsp_index_ff;
   assign rsp_if.is_last_res  = rsp_last_ff;

endmodule
